>>> sv/ws2_pkg.sv
// ----------------------------------------------------------------------------
// ws2_pkg
// shared types and constants of the single-wire led transmitter
// ----------------------------------------------------------------------------
package ws2_pkg;

  localparam int ByteW     = 8;
  localparam int ScaleW    = 9;
  localparam int TickW     = 8;
  localparam int BitCntW   = 4;
  localparam int QueueDepth = 2;
  localparam int AddrW     = 4;
  localparam int DataW     = 32;

  localparam logic [ScaleW-1:0] IntensityMax   = 9'd256;
  localparam logic [ScaleW-1:0] IntensityReset = 9'd256;
  localparam logic [TickW-1:0]  ZeroHighReset  = 8'd16;
  localparam logic [TickW-1:0]  OneHighReset   = 8'd43;
  localparam logic [TickW-1:0]  PeriodReset    = 8'd60;
  localparam logic [BitCntW-1:0] BitsPerByte   = 4'd8;

  typedef enum logic [1:0] {
    REG_INTENSITY = 2'd0,
    REG_ZERO_HIGH = 2'd1,
    REG_ONE_HIGH  = 2'd2,
    REG_PERIOD    = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic [ScaleW-1:0] intensity;
    logic [TickW-1:0]  zero_high_ticks;
    logic [TickW-1:0]  one_high_ticks;
    logic [TickW-1:0]  bit_period_ticks;
  } cfg_t;

  typedef struct packed {
    logic             action;
    logic [ByteW-1:0] scaled_byte;
    logic             last_byte;
  } item_t;

  typedef struct packed {
    logic frame_done;
    logic byte_done;
    logic busy_res;
    logic accepted;
    logic line_level;
  } result_t;

endpackage

>>> sv/ws2_regs.sv
// ----------------------------------------------------------------------------
// ws2_regs
// apb register file for intensity and bit timing
// ----------------------------------------------------------------------------
module ws2_regs import ws2_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [AddrW-1:0] paddr,
  input  logic [DataW-1:0] pwdata,
  output logic [DataW-1:0] prdata,
  output cfg_t             cfg
);

  logic     wr_en;
  reg_idx_t idx;

  assign wr_en = psel && penable && pwrite;
  assign idx   = reg_idx_t'(paddr[3:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.intensity        <= IntensityReset;
      cfg.zero_high_ticks  <= ZeroHighReset;
      cfg.one_high_ticks   <= OneHighReset;
      cfg.bit_period_ticks <= PeriodReset;
    end else if (wr_en) begin
      case (idx)
        REG_INTENSITY: cfg.intensity        <= pwdata[ScaleW-1:0];
        REG_ZERO_HIGH: cfg.zero_high_ticks  <= pwdata[TickW-1:0];
        REG_ONE_HIGH:  cfg.one_high_ticks   <= pwdata[TickW-1:0];
        REG_PERIOD:    cfg.bit_period_ticks <= pwdata[TickW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_INTENSITY: prdata = {{(DataW-ScaleW){1'b0}}, cfg.intensity};
      REG_ZERO_HIGH: prdata = {{(DataW-TickW){1'b0}}, cfg.zero_high_ticks};
      REG_ONE_HIGH:  prdata = {{(DataW-TickW){1'b0}}, cfg.one_high_ticks};
      REG_PERIOD:    prdata = {{(DataW-TickW){1'b0}}, cfg.bit_period_ticks};
      default:       prdata = '0;
    endcase
  end

endmodule

>>> sv/ws2_front.sv
// ----------------------------------------------------------------------------
// ws2_front
// takes input words, scales the color byte and queues them for the encoder
// ----------------------------------------------------------------------------
module ws2_front import ws2_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic [ScaleW-1:0] intensity,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic             in_action,
  input  logic [ByteW-1:0] in_byte,
  input  logic             in_last,
  output logic             q_valid,
  input  logic             q_pop,
  output item_t            q_item
);

  localparam int PtrW = $clog2(QueueDepth);
  localparam int CntW = $clog2(QueueDepth + 1);

  item_t                 entries [QueueDepth];
  logic [PtrW-1:0]       wr_ptr;
  logic [PtrW-1:0]       rd_ptr;
  logic [CntW-1:0]       count;
  logic [ScaleW-1:0]     scale;
  logic [ByteW+ScaleW-1:0] product;
  item_t                 new_item;
  logic                  push;
  logic                  pop;

  assign scale   = (intensity > IntensityMax) ? IntensityMax : intensity;
  assign product = {{ScaleW{1'b0}}, in_byte} * {{ByteW{1'b0}}, scale};

  assign new_item.action      = in_action;
  assign new_item.scaled_byte = product[2*ByteW-1:ByteW];
  assign new_item.last_byte   = in_last;

  assign in_ready = (count != CntW'(QueueDepth));
  assign push     = in_valid && in_ready;
  assign q_valid  = (count != '0);
  assign pop      = q_pop && q_valid;
  assign q_item   = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= new_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PtrW'(QueueDepth - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PtrW'(QueueDepth - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

>>> sv/ws2_back.sv
// ----------------------------------------------------------------------------
// ws2_back
// bit encoder: byte buffer, shifter, bit timer and result register
// ----------------------------------------------------------------------------
module ws2_back import ws2_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  cfg_t    cfg,
  input  logic    q_valid,
  output logic    q_pop,
  input  item_t   q_item,
  output logic    out_valid,
  input  logic    out_ready,
  output result_t out_res
);

  logic [ByteW-1:0]   shift_reg, shift_reg_next;
  logic [BitCntW-1:0] bits_left, bits_left_next;
  logic [TickW-1:0]   tick_count, tick_count_next;
  logic               shifting_last, shifting_last_next;
  logic [ByteW-1:0]   buffer_byte, buffer_byte_next;
  logic               buffer_last, buffer_last_next;
  logic               buffer_full, buffer_full_next;
  result_t            res;

  logic [TickW-1:0]   period;
  logic [TickW-1:0]   high;
  logic [TickW:0]     tick_inc;
  logic [BitCntW-1:0] bits_mid;

  assign q_pop  = q_valid && (!out_valid || out_ready);
  assign period = (cfg.bit_period_ticks == '0) ? TickW'(1) : cfg.bit_period_ticks;
  assign high   = shift_reg[ByteW-1] ? cfg.one_high_ticks : cfg.zero_high_ticks;
  assign tick_inc = {1'b0, tick_count} + 1'b1;

  always_comb begin
    shift_reg_next     = shift_reg;
    bits_left_next     = bits_left;
    tick_count_next    = tick_count;
    shifting_last_next = shifting_last;
    buffer_byte_next   = buffer_byte;
    buffer_last_next   = buffer_last;
    buffer_full_next   = buffer_full;
    res                = '0;
    bits_mid           = bits_left;

    // bit timer
    if (bits_left != '0) begin
      res.line_level = (tick_count < high);
      if (tick_inc >= {1'b0, period}) begin
        tick_count_next = '0;
        shift_reg_next  = {shift_reg[ByteW-2:0], 1'b0};
        bits_mid        = bits_left - 1'b1;
        if (bits_mid == '0) begin
          res.byte_done  = 1'b1;
          res.frame_done = shifting_last;
        end
      end else begin
        tick_count_next = tick_inc[TickW-1:0];
      end
    end
    bits_left_next = bits_mid;

    // buffer to shifter
    if (bits_mid == '0 && buffer_full) begin
      shift_reg_next     = buffer_byte;
      bits_left_next     = BitsPerByte;
      tick_count_next    = '0;
      shifting_last_next = buffer_last;
      buffer_full_next   = 1'b0;
    end

    // offered byte into buffer
    if (q_item.action && !buffer_full) begin
      buffer_byte_next = q_item.scaled_byte;
      buffer_last_next = q_item.last_byte;
      buffer_full_next = 1'b1;
      res.accepted     = 1'b1;
    end

    res.busy_res = (bits_left_next != '0) || buffer_full_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      shift_reg     <= '0;
      bits_left     <= '0;
      tick_count    <= '0;
      shifting_last <= 1'b0;
      buffer_last   <= 1'b0;
      buffer_full   <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      if (q_pop) begin
        shift_reg     <= shift_reg_next;
        bits_left     <= bits_left_next;
        tick_count    <= tick_count_next;
        shifting_last <= shifting_last_next;
        buffer_last   <= buffer_last_next;
        buffer_full   <= buffer_full_next;
        out_valid     <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      buffer_byte <= buffer_byte_next;
      out_res     <= res;
    end
  end

endmodule

>>> sv/ws2812_led_transmitter.sv
// ----------------------------------------------------------------------------
// ws2812_led_transmitter
// single-wire led encoder with apb configuration and stream ports
// ----------------------------------------------------------------------------
// each input word is one tick of the bit timer and yields exactly one output
// word. a word can be taken every cycle while the input queue is not full; a
// result word passes through the two-entry input queue and then the output
// register of the encoder, which can hold it while the receiver stalls. the
// offered byte is scaled as byte * intensity >> 8 on entry.
module ws2812_led_transmitter import ws2_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  output logic             s_tready,
  input  logic [7:0]       s_tdata,   // [7:0] data_byte
  input  logic             s_tuser,   // [0] action
  input  logic             s_tlast,   // last_byte
  output logic             m_tvalid,
  input  logic             m_tready,
  output logic [7:0]       m_tdata,   // [0] line_level [1] accepted [2] busy_res
                                      // [3] byte_done [4] frame_done [7:5] zero
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [AddrW-1:0] paddr,
  input  logic [DataW-1:0] pwdata,
  output logic [DataW-1:0] prdata,
  output logic             pready
);

  cfg_t    cfg;
  logic    q_valid;
  logic    q_pop;
  item_t   q_item;
  result_t res;

  assign pready = 1'b1;

  ws2_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .cfg     (cfg)
  );

  ws2_front u_front (
    .clk       (clk),
    .rst       (rst),
    .intensity (cfg.intensity),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_action (s_tuser),
    .in_byte   (s_tdata),
    .in_last   (s_tlast),
    .q_valid   (q_valid),
    .q_pop     (q_pop),
    .q_item    (q_item)
  );

  ws2_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .q_valid   (q_valid),
    .q_pop     (q_pop),
    .q_item    (q_item),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_res   (res)
  );

  assign m_tdata = {3'b000, res};

endmodule

>>> verif/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// stream-level testbench of the single-wire led transmitter
// ----------------------------------------------------------------------------
// every accepted input word is one tick of the bit timer. an internal encoder
// model predicts the output word of each tick from its own copy of the
// shifter, buffer and timing registers. output words are checked in order.
// the run walks through several timing and intensity settings written over
// apb between phases, with random sender gaps and receiver stalls.
module tb_top;
  import ws2_pkg::*;

  localparam int CycleLimit = 200000;
  localparam int ReportMax  = 10;

  typedef struct packed {
    logic             action;
    logic [ByteW-1:0] data;
    logic             last;
  } tick_word_t;

  logic             clk;
  logic             rst;
  logic             s_tvalid = 1'b0;
  logic             s_tready;
  logic [7:0]       s_tdata = '0;   // [7:0] data_byte
  logic             s_tuser = 1'b0; // [0] action
  logic             s_tlast = 1'b0;
  logic             m_tvalid;
  logic             m_tready = 1'b0;
  logic [7:0]       m_tdata;        // [0] line_level [1] accepted [2] busy_res
                                    // [3] byte_done [4] frame_done
  logic             psel = 1'b0;
  logic             penable = 1'b0;
  logic             pwrite = 1'b0;
  logic [AddrW-1:0] paddr = '0;
  logic [DataW-1:0] pwdata = '0;
  logic [DataW-1:0] prdata;
  logic             pready;

  tick_word_t tick_q[$];
  result_t    line_exp_q[$];

  // encoder model state
  cfg_t               led_cfg;
  logic [ByteW-1:0]   shift_byte;
  logic [BitCntW-1:0] bits_rem;
  logic [TickW-1:0]   tick_cnt;
  logic               shift_last;
  logic [ByteW-1:0]   hold_byte;
  logic               hold_last;
  logic               hold_full;

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int err_cnt        = 0;
  int cycle_cnt      = 0;

  ws2812_led_transmitter DUT (.*);

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic result_t encode_tick(input tick_word_t w);
    logic [TickW-1:0]  period;
    logic [ScaleW-1:0] scale;
    logic [TickW-1:0]  high;
    logic [16:0]       prod;
    logic              was_full;
    result_t           r;
    r        = '0;
    period   = (led_cfg.bit_period_ticks == 0) ? 8'd1 : led_cfg.bit_period_ticks;
    scale    = (led_cfg.intensity > IntensityMax) ? IntensityMax : led_cfg.intensity;
    was_full = hold_full;
    if (bits_rem != 0) begin
      high = shift_byte[7] ? led_cfg.one_high_ticks : led_cfg.zero_high_ticks;
      r.line_level = (tick_cnt < high);
      if ({1'b0, tick_cnt} + 9'd1 >= {1'b0, period}) begin
        tick_cnt   = '0;
        shift_byte = shift_byte << 1;
        bits_rem   = bits_rem - 1'b1;
        if (bits_rem == 0) begin
          r.byte_done  = 1'b1;
          r.frame_done = shift_last;
        end
      end else begin
        tick_cnt = tick_cnt + 1'b1;
      end
    end
    if (bits_rem == 0 && was_full) begin
      shift_byte = hold_byte;
      bits_rem   = BitsPerByte;
      tick_cnt   = '0;
      shift_last = hold_last;
      hold_full  = 1'b0;
    end
    if (w.action && !was_full) begin
      prod       = w.data * scale;
      hold_byte  = prod[15:8];
      hold_last  = w.last;
      hold_full  = 1'b1;
      r.accepted = 1'b1;
    end
    r.busy_res = (bits_rem != 0) || hold_full;
    return r;
  endfunction

  // driver
  always @(posedge clk) begin : drv
    tick_word_t w;
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || s_tready) begin
      if (s_tvalid) line_exp_q.push_back(encode_tick(tick_word_t'{s_tuser, s_tdata, s_tlast}));
      if (tick_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        w = tick_q.pop_front();
        s_tvalid <= 1'b1;
        s_tuser  <= w.action;
        s_tdata  <= w.data;
        s_tlast  <= w.last;
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk) begin : mon
    result_t got;
    result_t want;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= recv_stall_pct);
      if (m_tvalid && m_tready) begin
        got = result_t'(m_tdata[4:0]);
        if (line_exp_q.size() == 0) begin
          err_cnt++;
          if (err_cnt <= ReportMax) $display("unexpected output word %b", m_tdata);
        end else begin
          want = line_exp_q.pop_front();
          if (got.line_level !== want.line_level || got.accepted !== want.accepted ||
              got.busy_res !== want.busy_res || got.byte_done !== want.byte_done ||
              got.frame_done !== want.frame_done) begin
            err_cnt++;
            if (err_cnt <= ReportMax)
              $display("mismatch line/acc/busy/bdone/fdone exp %b%b%b%b%b got %b%b%b%b%b",
                       want.line_level, want.accepted, want.busy_res, want.byte_done,
                       want.frame_done, got.line_level, got.accepted, got.busy_res,
                       got.byte_done, got.frame_done);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CycleLimit) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  task automatic write_reg(input reg_idx_t idx, input logic [DataW-1:0] val);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= AddrW'({idx, 2'b00});
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_INTENSITY: led_cfg.intensity        = val[ScaleW-1:0];
      REG_ZERO_HIGH: led_cfg.zero_high_ticks  = val[TickW-1:0];
      REG_ONE_HIGH:  led_cfg.one_high_ticks   = val[TickW-1:0];
      REG_PERIOD:    led_cfg.bit_period_ticks = val[TickW-1:0];
      default: ;
    endcase
  endtask

  task automatic wait_drained;
    @(negedge clk);
    while (tick_q.size() != 0 || s_tvalid || line_exp_q.size() != 0) @(negedge clk);
  endtask

  task automatic load_timing(input int inten, input int zero_hi, input int one_hi,
                             input int period, input int mode);
    wait_drained();
    repeat (4) @(posedge clk);
    write_reg(REG_INTENSITY, inten);
    write_reg(REG_ZERO_HIGH, zero_hi);
    write_reg(REG_ONE_HIGH, one_hi);
    write_reg(REG_PERIOD, period);
    case (mode % 4)
      0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
      1: begin send_idle_pct = 54; recv_stall_pct = 0;  end
      2: begin send_idle_pct = 0;  recv_stall_pct = 54; end
      default: begin send_idle_pct = 36; recv_stall_pct = 36; end
    endcase
  endtask

  task automatic queue_ticks(input int n, input int act_pct);
    tick_word_t w;
    for (int i = 0; i < n; i++) begin
      w.action = ($urandom_range(99) < act_pct);
      w.data   = $urandom_range(255);
      w.last   = ($urandom_range(3) == 0);
      tick_q.push_back(w);
    end
  endtask

  task automatic push_tick(input logic action, input logic [7:0] data, input logic last);
    tick_q.push_back(tick_word_t'{action, data, last});
  endtask

  initial begin : stim
    int period;
    int act_sel [3];
    act_sel    = '{5, 35, 80};
    led_cfg    = '{IntensityReset, ZeroHighReset, OneHighReset, PeriodReset};
    shift_byte = '0;
    bits_rem   = '0;
    tick_cnt   = '0;
    shift_last = 1'b0;
    hold_byte  = '0;
    hold_last  = 1'b0;
    hold_full  = 1'b0;
    rst = 1'b1;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // intensity above full scale, zero bit never high, one bit high all period
    load_timing(511, 0, 3, 2, 0);
    push_tick(1'b0, 8'hA5, 1'b1);
    push_tick(1'b1, 8'hFF, 1'b0);
    push_tick(1'b1, 8'h00, 1'b1);  // refused while buffer still full
    push_tick(1'b1, 8'h00, 1'b1);
    push_tick(1'b1, 8'h80, 1'b0);
    for (int i = 0; i < 17; i++) push_tick(1'b0, $urandom_range(255), i[0]);
    push_tick(1'b1, 8'h01, 1'b1);
    push_tick(1'b1, 8'h7F, 1'b0);

    load_timing(256, 16, 43, 60, 1);
    queue_ticks(120, 30);
    load_timing(0, 1, 255, 255, 2);
    queue_ticks(300, 30);
    load_timing($urandom_range(257, 511), 255, 1, 0, 3);
    queue_ticks(200, 35);
    load_timing(128, 2, 2, 1, 0);
    queue_ticks(150, 35);
    for (int p = 0; p < 6; p++) begin
      period = $urandom_range(2, 8);
      load_timing($urandom_range(0, 256), $urandom_range(0, period + 1),
                  $urandom_range(0, period + 1), period, p + 1);
      queue_ticks(200, act_sel[p % 3]);
    end

    wait_drained();
    repeat (20) @(negedge clk);
    if (err_cnt == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

>>> sim.f
sv/ws2_pkg.sv
sv/ws2_regs.sv
sv/ws2_front.sv
sv/ws2_back.sv
sv/ws2812_led_transmitter.sv
verif/tb_top.sv
